// ----- src/range_boundary_clip_fold_wrap_unit_defines.svh -----
// Assertion macros shared by the range limiter RTL.
`ifndef RANGE_BOUNDARY_CLIP_FOLD_WRAP_UNIT_DEFINES_SVH
`define RANGE_BOUNDARY_CLIP_FOLD_WRAP_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBCFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBCFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rbcfw_pkg.sv -----
// Package with register indexes, mode codes and result operation codes.
`default_nettype none
package rbcfw_pkg;

    localparam int unsigned CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_MIN    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_MAX    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_MODE   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_MODE   = 3'd4;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_MUTE  = 3'd1;
    localparam logic [2:0] MODE_CLAMP = 3'd2;
    localparam logic [2:0] MODE_FOLD  = 3'd3;
    localparam logic [2:0] MODE_WRAP  = 3'd4;

    typedef enum logic [2:0] {
        OP_PASS,
        OP_MIN_PLUS,
        OP_MAX_MINUS,
        OP_FOLD_TOP,
        OP_FOLD_BOT
    } op_t;

endpackage
`default_nettype wire

// ----- src/range_boundary_clip_fold_wrap_unit.sv -----
// Top level of the range limiter: clamp, fold, wrap and mute against a configured range.
`default_nettype none
`include "range_boundary_clip_fold_wrap_unit_defines.svh"
// One word enters per clock cycle when the output side keeps up. A word passes
// VALUE_WIDTH + 5 registers (an input register, a classify stage, VALUE_WIDTH + 2
// stages of a restoring divider that yields one quotient bit each, and an output
// register); the first loads at the accepting edge. Stalls on the output fill
// empty stages before the input is held back. Configuration may be written only
// while no word is in flight.
module range_boundary_clip_fold_wrap_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [rbcfw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]               cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // Fields from bit 0: sample.
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // Fields from bit 0: limited.
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]          m_tdata,
    // Fields from bit 0: muted.
    output logic                                      m_tuser
);
    import rbcfw_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int BW = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int EW = VW + 3;
    localparam int DW = VW + 2;
    localparam int RW = VW + 1;
    localparam int NS = DW + 1;

    logic                 enable_reg;
    logic signed [VW-1:0] min_reg;
    logic signed [VW-1:0] max_reg;
    logic [2:0]           lower_reg;
    logic [2:0]           upper_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            min_reg    <= '0;
            max_reg    <= VW'(65536);
            lower_reg  <= MODE_NONE;
            upper_reg  <= MODE_NONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RANGE_ENABLE: enable_reg <= cfg_wdata[0];
                REG_RANGE_MIN:    min_reg    <= cfg_wdata;
                REG_RANGE_MAX:    max_reg    <= cfg_wdata;
                REG_LOWER_MODE:   lower_reg  <= cfg_wdata[2:0];
                REG_UPPER_MODE:   upper_reg  <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    logic signed [EW-1:0] mn;
    logic signed [EW-1:0] mx;
    logic signed [EW-1:0] span;
    logic [RW-1:0]        wabs;
    logic                 wzero;

    assign mn    = EW'(min_reg);
    assign mx    = EW'(max_reg);
    assign span  = mx - mn;
    assign wabs  = span[EW-1] ? RW'(-span) : RW'(span);
    assign wzero = (wabs == '0);

    logic                 in_vld_reg;
    logic signed [VW-1:0] in_smp_reg;
    logic                 vld_reg [NS];
    op_t                  op_reg  [NS];
    logic                 mut_reg [NS];
    logic signed [EW-1:0] val_reg [NS];
    logic [DW-1:0]        dvd_reg [NS];
    logic [RW-1:0]        rem_reg [NS];
    logic                 qb_reg  [NS];
    logic                 en_p    [NS];
    logic                 en_out;
    logic                 en_in;

    assign en_out = !m_tvalid || m_tready;
    assign en_p[NS-1] = !vld_reg[NS-1] || en_out;
    for (genvar j = 0; j < NS - 1; j++) begin : g_ready
        assign en_p[j] = !vld_reg[j] || en_p[j+1];
    end
    assign en_in    = !in_vld_reg || en_p[0];
    assign s_tready = en_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en_in) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_in) begin
            in_smp_reg <= s_tdata[VW-1:0];
        end
    end

    logic signed [EW-1:0] se;
    logic signed [EW-1:0] dl;
    logic signed [EW-1:0] du;
    logic signed [EW-1:0] v2l;
    logic signed [EW-1:0] v2u;
    logic signed [EW-1:0] el;
    logic signed [EW-1:0] eu;
    op_t                  c_op;
    logic                 c_mut;
    logic signed [EW-1:0] c_val;
    logic signed [EW-1:0] c_exc;

    assign se  = EW'(in_smp_reg);
    assign dl  = mn - se;
    assign du  = se - mx;
    assign v2l = mn + dl;
    assign v2u = mx - du;
    assign el  = v2l - mx;
    assign eu  = mn - v2u;

    always_comb begin
        c_op  = OP_PASS;
        c_mut = 1'b0;
        c_val = se;
        c_exc = '0;
        if (enable_reg) begin
            if (se < mn) begin
                priority case (lower_reg)
                    MODE_MUTE:  c_mut = 1'b1;
                    MODE_CLAMP: c_val = mn;
                    MODE_WRAP: begin
                        c_op  = OP_MAX_MINUS;
                        c_exc = dl;
                    end
                    MODE_FOLD: begin
                        c_val = v2l;
                        if (v2l > mx) begin
                            c_exc = el;
                            priority case (upper_reg)
                                MODE_MUTE:  c_mut = 1'b1;
                                MODE_CLAMP: c_val = mx;
                                MODE_FOLD:  c_op  = OP_FOLD_TOP;
                                MODE_WRAP:  c_op  = OP_MIN_PLUS;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end else if (se > mx) begin
                priority case (upper_reg)
                    MODE_MUTE:  c_mut = 1'b1;
                    MODE_CLAMP: c_val = mx;
                    MODE_WRAP: begin
                        c_op  = OP_MIN_PLUS;
                        c_exc = du;
                    end
                    MODE_FOLD: begin
                        c_val = v2u;
                        if (v2u < mn) begin
                            c_exc = eu;
                            priority case (lower_reg)
                                MODE_MUTE:  c_mut = 1'b1;
                                MODE_CLAMP: c_val = mn;
                                MODE_FOLD:  c_op  = OP_FOLD_BOT;
                                MODE_WRAP:  c_op  = OP_MAX_MINUS;
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en_p[0]) begin
            vld_reg[0] <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p[0]) begin
            op_reg[0]  <= c_op;
            mut_reg[0] <= c_mut;
            val_reg[0] <= c_val;
            dvd_reg[0] <= c_exc[DW-1:0];
            rem_reg[0] <= '0;
            qb_reg[0]  <= 1'b0;
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_div
        logic [RW:0]   trial;
        logic          take;
        logic [RW-1:0] rem_next;

        assign trial    = {rem_reg[j-1], dvd_reg[j-1][DW-1]};
        assign take     = (trial >= {1'b0, wabs});
        assign rem_next = take ? RW'(trial - {1'b0, wabs}) : trial[RW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en_p[j]) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en_p[j]) begin
                op_reg[j]  <= op_reg[j-1];
                mut_reg[j] <= mut_reg[j-1];
                val_reg[j] <= val_reg[j-1];
                dvd_reg[j] <= {dvd_reg[j-1][DW-2:0], 1'b0};
                rem_reg[j] <= rem_next;
                qb_reg[j]  <= take;
            end
        end
    end

    logic signed [EW-1:0] m_ext;
    logic signed [EW-1:0] r_minp;
    logic signed [EW-1:0] r_maxm;
    logic signed [EW-1:0] r_val;
    logic                 fits;
    logic [VW-1:0]        sat;

    assign m_ext  = EW'(rem_reg[NS-1]);
    assign r_minp = mn + m_ext;
    assign r_maxm = mx - m_ext;

    always_comb begin
        unique case (op_reg[NS-1])
            OP_PASS:      r_val = val_reg[NS-1];
            OP_MIN_PLUS:  r_val = wzero ? mn : r_minp;
            OP_MAX_MINUS: r_val = wzero ? mn : r_maxm;
            OP_FOLD_TOP:  r_val = wzero ? mn : (qb_reg[NS-1] ? r_minp : r_maxm);
            OP_FOLD_BOT:  r_val = wzero ? mn : (qb_reg[NS-1] ? r_maxm : r_minp);
            default:      r_val = val_reg[NS-1];
        endcase
    end

    assign fits = (r_val[EW-1:VW-1] == {(EW-VW+1){r_val[EW-1]}});
    assign sat  = fits ? r_val[VW-1:0]
                : (r_val[EW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

    logic [VW-1:0] lim_reg;
    logic          mvld_reg;
    logic          mmut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= 1'b0;
        end else if (en_out) begin
            mvld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            lim_reg  <= sat;
            mmut_reg <= mut_reg[NS-1];
        end
    end

    assign m_tvalid = mvld_reg;
    assign m_tdata  = BW'(lim_reg);
    assign m_tuser  = mmut_reg;

    `RBCFW_ASSERT_NOW(a_empty_out_ready, !m_tvalid, s_tready, "input held while output empty")
    `RBCFW_ASSERT_NEXT(a_in_stage_hold, in_vld_reg && !en_p[0], in_vld_reg, "input stage lost word")
    `RBCFW_ASSERT_NEXT(a_last_stage_hold, vld_reg[NS-1] && !en_out, vld_reg[NS-1], "last stage lost word")

endmodule
`default_nettype wire

// ----- tb/range_boundary_clip_fold_wrap_unit_test.sv -----
// Testbench for the range limiter: directed and random samples checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module range_boundary_clip_fold_wrap_unit_test;
    import rbcfw_pkg::*;

    localparam int VW = 32;
    localparam int LATENCY = VW + 5;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [VW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [VW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [VW-1:0] m_tdata;
    logic m_tuser;

    range_boundary_clip_fold_wrap_unit #(.VALUE_WIDTH(VW)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        logic [VW-1:0] limited;
        logic          muted;
    } limit_result_t;

    limit_result_t expected_limits[$];
    bit failed = 0;
    bit rx_idle_on = 1;
    bit tx_idle_on = 1;
    int hold_off_cycles = 0;
    int idle_cycles = 0;

    logic       cur_enable;
    logic signed [63:0] cur_min, cur_max;
    logic [2:0] cur_lower, cur_upper;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [63:0] span();
        logic signed [63:0] w;
        w = cur_max - cur_min;
        return w < 0 ? -w : w;
    endfunction

    function automatic logic signed [63:0] fold_back(logic signed [63:0] exc, bit from_top);
        logic signed [63:0] w, q, m;
        w = span();
        if (w == 0) return cur_min;
        q = exc / w;
        m = exc % w;
        if (from_top) return (q[0] == 1'b0) ? cur_max - m : cur_min + m;
        return (q[0] == 1'b0) ? cur_min + m : cur_max - m;
    endfunction

    function automatic logic signed [63:0] wrap_back(logic signed [63:0] exc, bit to_min);
        logic signed [63:0] w;
        w = span();
        if (w == 0) return cur_min;
        return to_min ? cur_min + exc % w : cur_max - exc % w;
    endfunction

    function automatic limit_result_t limit_sample(logic [VW-1:0] raw);
        logic signed [63:0] v, e;
        limit_result_t r;
        v = {{32{raw[VW-1]}}, raw};
        r.muted = 1'b0;
        if (cur_enable) begin
            if (v < cur_min) begin
                case (cur_lower)
                    MODE_MUTE: r.muted = 1'b1;
                    MODE_CLAMP: v = cur_min;
                    MODE_WRAP: v = wrap_back(cur_min - v, 0);
                    MODE_FOLD: begin
                        v = 2 * cur_min - v;
                        if (v > cur_max) begin
                            e = v - cur_max;
                            case (cur_upper)
                                MODE_MUTE: r.muted = 1'b1;
                                MODE_CLAMP: v = cur_max;
                                MODE_FOLD: v = fold_back(e, 1);
                                MODE_WRAP: v = wrap_back(e, 1);
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end else if (v > cur_max) begin
                case (cur_upper)
                    MODE_MUTE: r.muted = 1'b1;
                    MODE_CLAMP: v = cur_max;
                    MODE_WRAP: v = wrap_back(v - cur_max, 1);
                    MODE_FOLD: begin
                        v = 2 * cur_max - v;
                        if (v < cur_min) begin
                            e = cur_min - v;
                            case (cur_lower)
                                MODE_MUTE: r.muted = 1'b1;
                                MODE_CLAMP: v = cur_min;
                                MODE_FOLD: v = fold_back(e, 0);
                                MODE_WRAP: v = wrap_back(e, 0);
                                default: ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        r.limited = v[VW-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [VW-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RANGE_ENABLE: cur_enable = val[0];
            REG_RANGE_MIN: cur_min = {{32{val[VW-1]}}, val};
            REG_RANGE_MAX: cur_max = {{32{val[VW-1]}}, val};
            REG_LOWER_MODE: cur_lower = val[2:0];
            REG_UPPER_MODE: cur_upper = val[2:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic en, logic [VW-1:0] mn, logic [VW-1:0] mx,
                             logic [2:0] lo, logic [2:0] up);
        write_reg(REG_RANGE_ENABLE, {31'b0, en});
        write_reg(REG_RANGE_MIN, mn);
        write_reg(REG_RANGE_MAX, mx);
        write_reg(REG_LOWER_MODE, {29'b0, lo});
        write_reg(REG_UPPER_MODE, {29'b0, up});
    endtask

    task automatic drain();
        while (expected_limits.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Sends one word and holds it until accepted; while tx_idle_on, the valid may drop for a random gap before it.
    task automatic send_sample(logic [VW-1:0] value);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        expected_limits.push_back(limit_sample(value));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] near_value();
        logic [VW-1:0] base;
        case ($urandom_range(0, 4))
            0: base = cur_min[VW-1:0];
            1: base = cur_max[VW-1:0];
            2: base = 32'h8000_0000;
            3: base = 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
        return base + $urandom_range(0, 8) - 4 + ($urandom_range(0, 1) ? $urandom_range(0, 1 << 20) : 0);
    endfunction

    function automatic logic [VW-1:0] rand_bound();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    task automatic test_passthrough();
        configure(1'b0, 32'h0, 32'h0001_0000, MODE_CLAMP, MODE_CLAMP);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0);
        send_sample(32'hFFFF_FFFF);
        stop_sending();
        drain();
    endtask

    task automatic test_each_mode();
        logic [2:0] modes[7];
        modes = '{MODE_NONE, MODE_MUTE, MODE_CLAMP, MODE_FOLD, MODE_WRAP, 3'd5, 3'd7};
        foreach (modes[i]) begin
            configure(1'b1, 32'hFFFF_0000, 32'h0002_8000, modes[i], modes[(i + 3) % 7]);
            send_sample(32'h8000_0000);
            send_sample(32'h7FFF_FFFF);
            send_sample(32'hFFF0_0000);
            send_sample(32'h0010_0000);
            send_sample(32'h0000_1234);
            stop_sending();
            drain();
        end
        // Zero-width and inverted ranges.
        configure(1'b1, 32'h0001_0000, 32'h0001_0000, MODE_FOLD, MODE_WRAP);
        send_sample(32'h0);
        send_sample(32'h0003_0000);
        stop_sending();
        drain();
        configure(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, MODE_FOLD, MODE_FOLD);
        send_sample(32'h0);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        stop_sending();
        drain();
    endtask

    task automatic test_random(int rounds, int per_round);
        repeat (rounds) begin
            configure($urandom_range(0, 7) != 0, rand_bound(), rand_bound(),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            repeat (per_round) send_sample(near_value());
            stop_sending();
            drain();
        end
    endtask

    task automatic test_back_pressure();
        configure(1'b1, 32'hFFFE_0000, 32'h0003_0000, MODE_FOLD, MODE_WRAP);
        hold_off_cycles = 3 * LATENCY;
        repeat (80) send_sample(near_value());
        stop_sending();
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        cur_enable = 0; cur_min = 0; cur_max = 65536; cur_lower = 0; cur_upper = 0;
        repeat (2) @(posedge aclk);
        test_passthrough();
        test_each_mode();
        test_back_pressure();
        test_random(30, 35);
        rx_idle_on = 0;
        tx_idle_on = 0;
        test_random(5, 40);
        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on && m_tready && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        limit_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_limits.size() == 0) begin
                $display("%0t: unexpected word limited=%h muted=%b", $time, m_tdata, m_tuser);
                failed = 1;
            end else begin
                want = expected_limits.pop_front();
                if (m_tdata !== want.limited) begin
                    $display("%0t: limited expected %h actual %h", $time, want.limited, m_tdata);
                    failed = 1;
                end
                if (m_tuser !== want.muted) begin
                    $display("%0t: muted expected %b actual %b", $time, want.muted, m_tuser);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we ||
            expected_limits.size() == 0) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire
